// ===== hw/rtl/utf8_hangul_jamo_composer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 Hangul jamo composer: assertion macros
// Shared immediate-implication and next-cycle forms, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_HANGUL_JAMO_COMPOSER_UNIT_DEFINES_SVH
`define UTF8_HANGUL_JAMO_COMPOSER_UNIT_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent
`define UJC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent
`define UJC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ujc_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 Hangul jamo composer: package
// Item types, the command passed from the decoder to the serialiser, Hangul
// constants and the UTF-8 encoding helpers.
// ----------------------------------------------------------------------------
package ujc_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // One decoded step: flushed held code, then '?' marks, then a code point
  typedef struct packed {
    logic        fl_en;
    logic [15:0] fl_code;
    logic [2:0]  marks;
    logic [2:0]  cp_len;   // zero when no code point follows
    logic [20:0] cp;
    logic        last;
  } cmd_t;

  typedef enum logic [2:0] {
    HK_NONE = 3'b001,
    HK_L    = 3'b010,
    HK_LV   = 3'b100
  } held_kind_e;

  localparam logic [15:0] SYL_BASE  = 16'hAC00;
  localparam logic [15:0] L_BASE    = 16'h1100;
  localparam logic [15:0] V_BASE    = 16'h1161;
  localparam logic [15:0] T_BASE    = 16'h11A7;
  localparam int          L_COUNT   = 19;
  localparam int          V_COUNT   = 21;
  localparam int          T_COUNT   = 28;
  localparam int          PER_L     = V_COUNT * T_COUNT;
  localparam int          SYL_COUNT = L_COUNT * PER_L;
  localparam logic [20:0] MAX_CP    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [7:0]  LEAD2_MIN = 8'hC2;
  localparam logic [7:0]  LEAD2_MAX = 8'hDF;
  localparam logic [7:0]  LEAD3_MIN = 8'hE0;
  localparam logic [7:0]  LEAD3_MAX = 8'hEF;
  localparam logic [7:0]  LEAD4_MIN = 8'hF0;
  localparam logic [7:0]  LEAD4_MAX = 8'hF4;
  localparam logic [7:0]  MARK_BYTE = 8'h3F;

  // x / 7 as (x * 9363) >> 16, exact for x below 2^12
  localparam logic [13:0] DIV7_MUL  = 14'd9363;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp <= 21'h7F) begin
      len = 3'd1;
    end else if (cp <= 21'h7FF) begin
      len = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [1:0] j);
    logic [7:0] b;
    b = 8'h00;
    unique case (len)
      3'd1: b = cp[7:0];
      3'd2: b = (j == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        unique case (j)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd4: begin
        unique case (j)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          2'd3: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/ujc_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-8 Hangul jamo composer: command queue
// Short register queue between the decoder and the byte serialiser.
// ----------------------------------------------------------------------------
module ujc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ujc_pkg::cmd_t entry_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output ujc_pkg::cmd_t head_o
);

  ujc_pkg::cmd_t                   mem_q [ujc_pkg::QDEPTH];
  logic [ujc_pkg::QPTR_W-1:0]      wptr_q, wptr_d;
  logic [ujc_pkg::QPTR_W-1:0]      rptr_q, rptr_d;
  logic [ujc_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == ujc_pkg::QCNT_W'(ujc_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

// ===== hw/rtl/ujc_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 Hangul jamo composer: decoder front end
// Validates UTF-8 sequences, composes conjoining jamo and turns each input
// byte into at most one command for the serialiser.
// ----------------------------------------------------------------------------
module ujc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ujc_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  output ujc_pkg::cmd_t     cmd_o
);

  logic [20:0]         acc_q, acc_d;
  logic [2:0]          len_q, len_d;
  logic [2:0]          rcv_q, rcv_d;
  logic [15:0]         code_q, code_d;
  ujc_pkg::held_kind_e kind_q, kind_d;

  ujc_pkg::cmd_t cmd;
  logic [7:0]    b;
  logic [20:0]   acc_n;
  logic [2:0]    rcv_n;
  logic          bad, do_lead, do_acc, done;
  logic [20:0]   c;

  // classification of the code point handed to the composer
  logic          is_l, is_v, is_t, is_lv, lv_rng;
  logic [20:0]   lv_off;
  logic [11:0]   lv_x;
  logic [25:0]   lv_prod;
  logic [9:0]    lv_q;
  logic [11:0]   lv_r;
  logic [4:0]    l_idx, v_idx;
  logic [15:0]   lv_code;

  assign b = in_item_i.in_byte;

  always_comb begin
    is_l    = (c >= 21'(ujc_pkg::L_BASE)) &&
              (c < 21'(ujc_pkg::L_BASE) + 21'(ujc_pkg::L_COUNT));
    is_v    = (c >= 21'(ujc_pkg::V_BASE)) &&
              (c < 21'(ujc_pkg::V_BASE) + 21'(ujc_pkg::V_COUNT));
    is_t    = (c > 21'(ujc_pkg::T_BASE)) &&
              (c < 21'(ujc_pkg::T_BASE) + 21'(ujc_pkg::T_COUNT));
    lv_off  = c - 21'(ujc_pkg::SYL_BASE);
    lv_rng  = (c >= 21'(ujc_pkg::SYL_BASE)) && (lv_off < 21'(ujc_pkg::SYL_COUNT));
    // precomposed LV syllable: offset divisible by 28 = 4 * 7
    lv_x    = lv_off[13:2];
    lv_prod = 26'(lv_x) * 26'(ujc_pkg::DIV7_MUL);
    lv_q    = lv_prod[25:16];
    lv_r    = 12'(13'(lv_x) - ({lv_q, 3'b000} - {3'b000, lv_q}));
    is_lv   = lv_rng && (lv_off[1:0] == 2'b00) && (lv_r == '0);
    l_idx   = code_q[4:0];
    v_idx   = 5'(c[15:0] - ujc_pkg::V_BASE);
    lv_code = ujc_pkg::SYL_BASE + 16'(l_idx) * 16'(ujc_pkg::PER_L) +
              16'(v_idx) * 16'(ujc_pkg::T_COUNT);
  end

  always_comb begin
    acc_d   = acc_q;
    len_d   = len_q;
    rcv_d   = rcv_q;
    code_d  = code_q;
    kind_d  = kind_q;
    cmd     = '0;
    cmd.fl_code = code_q;
    cmd.last    = in_item_i.in_last;
    acc_n   = {acc_q[14:0], b[5:0]};
    rcv_n   = rcv_q + 3'd1;
    bad     = 1'b0;
    do_lead = 1'b0;
    do_acc  = 1'b0;
    done    = 1'b0;
    c       = '0;

    if (len_q == '0) begin
      do_lead = 1'b1;
    end else if (b[7:6] != 2'b10) begin
      // broken sequence: flush, mark what was taken, rescan this byte as a lead
      cmd.marks = rcv_q;
      if (kind_d != ujc_pkg::HK_NONE) cmd.fl_en = 1'b1;
      kind_d  = ujc_pkg::HK_NONE;
      code_d  = '0;
      len_d   = '0;
      rcv_d   = '0;
      acc_d   = '0;
      do_lead = 1'b1;
    end else if (rcv_n < len_q) begin
      acc_d = acc_n;
      rcv_d = rcv_n;
    end else begin
      bad = ((len_q == 3'd3) && (acc_n < 21'h800)) ||
            ((len_q == 3'd4) && (acc_n < 21'h10000)) ||
            ((acc_n >= ujc_pkg::SURR_LO) && (acc_n <= ujc_pkg::SURR_HI)) ||
            (acc_n > ujc_pkg::MAX_CP);
      len_d = '0;
      rcv_d = '0;
      acc_d = '0;
      if (bad) begin
        cmd.marks = len_q;
        if (kind_d != ujc_pkg::HK_NONE) cmd.fl_en = 1'b1;
        kind_d = ujc_pkg::HK_NONE;
        code_d = '0;
      end else begin
        do_acc = 1'b1;
        c      = acc_n;
      end
    end

    if (do_lead) begin
      if (!b[7]) begin
        do_acc = 1'b1;
        c      = {13'd0, b};
      end else if ((b >= ujc_pkg::LEAD2_MIN) && (b <= ujc_pkg::LEAD2_MAX)) begin
        len_d = 3'd2;
        acc_d = {16'd0, b[4:0]};
        rcv_d = 3'd1;
      end else if ((b >= ujc_pkg::LEAD3_MIN) && (b <= ujc_pkg::LEAD3_MAX)) begin
        len_d = 3'd3;
        acc_d = {17'd0, b[3:0]};
        rcv_d = 3'd1;
      end else if ((b >= ujc_pkg::LEAD4_MIN) && (b <= ujc_pkg::LEAD4_MAX)) begin
        len_d = 3'd4;
        acc_d = {18'd0, b[2:0]};
        rcv_d = 3'd1;
      end else begin
        cmd.marks = cmd.marks + 3'd1;
        if (kind_d != ujc_pkg::HK_NONE) cmd.fl_en = 1'b1;
        kind_d = ujc_pkg::HK_NONE;
        code_d = '0;
      end
    end

    if (do_acc) begin
      unique case (kind_d)
        ujc_pkg::HK_L: begin
          if (is_v) begin
            code_d = lv_code;
            kind_d = ujc_pkg::HK_LV;
            done   = 1'b1;
          end else begin
            cmd.fl_en = 1'b1;
          end
        end
        ujc_pkg::HK_LV: begin
          if (is_t) begin
            cmd.cp     = {5'd0, code_d + (c[15:0] - ujc_pkg::T_BASE)};
            cmd.cp_len = 3'd3;
            kind_d     = ujc_pkg::HK_NONE;
            code_d     = '0;
            done       = 1'b1;
          end else begin
            cmd.fl_en = 1'b1;
          end
        end
        default: ;
      endcase
      if (!done) begin
        kind_d = ujc_pkg::HK_NONE;
        code_d = '0;
        if (is_l) begin
          code_d = c[15:0];
          kind_d = ujc_pkg::HK_L;
        end else if (is_lv) begin
          code_d = c[15:0];
          kind_d = ujc_pkg::HK_LV;
        end else begin
          cmd.cp     = c;
          cmd.cp_len = ujc_pkg::utf8_len(c);
        end
      end
    end

    if (in_item_i.in_last) begin
      // end of string: mark an open sequence, write out anything held, clear all
      if (len_d != '0) begin
        cmd.marks = cmd.marks + rcv_d;
        if (kind_d != ujc_pkg::HK_NONE) cmd.fl_en = 1'b1;
        kind_d = ujc_pkg::HK_NONE;
      end
      if (kind_d != ujc_pkg::HK_NONE) begin
        cmd.cp     = {5'd0, code_d};
        cmd.cp_len = 3'd3;
      end
      acc_d  = '0;
      len_d  = '0;
      rcv_d  = '0;
      code_d = '0;
      kind_d = ujc_pkg::HK_NONE;
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept_i && (cmd.fl_en || (cmd.marks != '0) || (cmd.cp_len != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      len_q  <= '0;
      rcv_q  <= '0;
      code_q <= '0;
      kind_q <= ujc_pkg::HK_NONE;
    end else if (accept_i) begin
      acc_q  <= acc_d;
      len_q  <= len_d;
      rcv_q  <= rcv_d;
      code_q <= code_d;
      kind_q <= kind_d;
    end
  end

endmodule

// ===== hw/rtl/ujc_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 Hangul jamo composer: byte serialiser
// Walks the command at the queue head one output byte per transfer.
// ----------------------------------------------------------------------------
module ujc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  ujc_pkg::cmd_t      head_i,
  input  logic               pop_i,
  output logic               empty_o,
  output ujc_pkg::out_item_t out_item_o,
  output logic               head_pop_o
);

  logic [3:0] idx_q, idx_d;
  logic [3:0] fl_n, mk_end, total;
  logic [1:0] j;
  logic       is_end;
  logic [7:0] byte_sel;

  always_comb begin
    fl_n   = head_i.fl_en ? 4'd3 : 4'd0;
    mk_end = fl_n + 4'(head_i.marks);
    total  = mk_end + 4'(head_i.cp_len);
    is_end = (idx_q == total - 4'd1);
    j      = 2'(idx_q - mk_end);
    if (idx_q < fl_n) begin
      byte_sel = ujc_pkg::utf8_byte({5'd0, head_i.fl_code}, 3'd3, idx_q[1:0]);
    end else if (idx_q < mk_end) begin
      byte_sel = ujc_pkg::MARK_BYTE;
    end else begin
      byte_sel = ujc_pkg::utf8_byte(head_i.cp, head_i.cp_len, j);
    end
  end

  assign empty_o             = !head_valid_i;
  assign out_item_o.out_byte = byte_sel;
  assign out_item_o.out_last = head_i.last && is_end;
  assign head_pop_o          = head_valid_i && pop_i && is_end;

  always_comb begin
    idx_d = idx_q;
    if (head_valid_i && pop_i) begin
      // advance within the command, or drop back to its start for the next one
      idx_d = is_end ? 4'd0 : idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== hw/rtl/utf8_hangul_jamo_composer_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 Hangul jamo composer
// Sanitises a UTF-8 byte stream and composes conjoining jamo into syllables.
//
//   channel  | direction | handshake     | payload
//   ---------+-----------+---------------+-------------------------------
//   input    | in        | push / full   | in_item_i  (in_byte, in_last)
//   result   | out       | pop / empty   | out_item_o (out_byte, out_last)
//
// Each input byte is decoded in the cycle it is accepted; one byte per cycle
// is taken while the four-entry command queue has room.
// An input byte yields 0 to 7 output bytes; the serialiser sends one byte per
// cycle while pop is high; the queued byte counts set the sustained rate.
// An item's command is registered in the queue before its result bytes show.
// Asynchronous active-low reset clears decoder state, queue and serialiser.
// ----------------------------------------------------------------------------
module utf8_hangul_jamo_composer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ujc_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output ujc_pkg::out_item_t out_item_o
);

  logic          accept;
  logic          cmd_valid;
  ujc_pkg::cmd_t cmd;
  logic          q_empty;
  ujc_pkg::cmd_t head;
  logic          head_pop;

  assign accept = push && !full;

  ujc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  ujc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .entry_i (cmd),
    .pop_i   (head_pop),
    .full_o  (full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  ujc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (head),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_item_o   (out_item_o),
    .head_pop_o   (head_pop)
  );

endmodule

// ===== hw/rtl/ujc_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 Hangul jamo composer: port checker
// Watches the top-level ports for a held result, well-formed UTF-8 output
// and end-of-string marks that follow an input end mark.
// ----------------------------------------------------------------------------
`include "utf8_hangul_jamo_composer_unit_defines.svh"

module ujc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input ujc_pkg::in_item_t  in_item_i,
  input logic               empty,
  input logic               pop,
  input ujc_pkg::out_item_t out_item_o
);

  logic       in_xfer, out_xfer;
  logic [1:0] cont_q, cont_d;
  logic [3:0] str_q, str_d;
  logic [7:0] ob;
  logic       lead_ok;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;
  assign ob       = out_item_o.out_byte;

  // a lead byte must be one that UTF-8 allows, and a multi-byte lead never ends
  assign lead_ok = (ob[7:6] != 2'b10) && (ob != 8'hC0) && (ob != 8'hC1) &&
                   (ob < 8'hF5) && !(out_item_o.out_last && (ob[7:6] == 2'b11));

  always_comb begin
    cont_d = cont_q;
    if (out_xfer) begin
      if (ob[7:5] == 3'b110) begin
        cont_d = 2'd1;
      end else if (ob[7:4] == 4'b1110) begin
        cont_d = 2'd2;
      end else if (ob[7:3] == 5'b11110) begin
        cont_d = 2'd3;
      end else if (cont_q != '0) begin
        cont_d = cont_q - 2'd1;
      end
    end
    str_d = str_q + 4'(in_xfer && in_item_i.in_last) - 4'(out_xfer && out_item_o.out_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_q <= '0;
      str_q  <= '0;
    end else begin
      cont_q <= cont_d;
      str_q  <= str_d;
    end
  end

  `UJC_ASSERT_NXT(a_out_hold, !empty && !pop, !empty && $stable(out_item_o),
                  "result changed while stalled")
  `UJC_ASSERT_IMP(a_cont_byte, out_xfer && (cont_q != 2'd0), ob[7:6] == 2'b10,
                  "continuation byte expected")
  `UJC_ASSERT_IMP(a_lead_byte, out_xfer && (cont_q == 2'd0), lead_ok,
                  "malformed lead byte in output")
  `UJC_ASSERT_IMP(a_last_src, out_xfer && out_item_o.out_last, str_q != 4'd0,
                  "end mark without an input end mark")

endmodule

bind utf8_hangul_jamo_composer_unit ujc_checker u_ujc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .in_item_i  (in_item_i),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
